### rtl/core/afc_pkg.sv
package afc_pkg;

	// Field widths
	localparam int INDEX_BITS = 16;
	localparam int COORD_BITS = 16;
	localparam int COEF_W     = 16;
	localparam int D_SHIFT    = 14;

	localparam int NUM_PLANES = 6;
	localparam int NUM_AXES   = 3;

	// Datapath widths
	localparam int PROD_W   = COEF_W + COORD_BITS;
	localparam int DSH_W    = COEF_W + D_SHIFT;
	localparam int SUM_W    = ((PROD_W > DSH_W) ? PROD_W : DSH_W) + 2;
	localparam int CNT_W    = INDEX_BITS + 1;

	// Stream widths, packed fields padded to whole bytes
	localparam int IN_FIELDS_W  = 2 * NUM_AXES * COORD_BITS;
	localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_FIELDS_W = INDEX_BITS + 1 + CNT_W + 1;
	localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

	// Queue between classifier and counter stage
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QLVL_W = $clog2(QDEPTH + 3);

	// Configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;

	localparam logic [CFG_IDX_W-1:0] REG_PLANE_LEFT   = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_PLANE_RIGHT  = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_PLANE_BOTTOM = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_PLANE_TOP    = CFG_IDX_W'(3);
	localparam logic [CFG_IDX_W-1:0] REG_PLANE_NEAR   = CFG_IDX_W'(4);
	localparam logic [CFG_IDX_W-1:0] REG_PLANE_FAR    = CFG_IDX_W'(5);

	// Plane word: a [15:0], b [31:16], c [47:32], d [63:48]
	typedef logic [CFG_DATA_W-1:0] plane_t;

	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [SUM_W-1:0]  sum_t;

	typedef struct packed {
		logic vis;
		logic last;
	} q_entry_t;

	typedef struct packed {
		logic v_s1;
		logic v_s2;
	} front_stat_t;

endpackage

### rtl/core/afc_front.sv
module afc_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic [afc_pkg::IN_DATA_W-1:0]  in_data,
	input  logic                           in_last,
	input  afc_pkg::plane_t                planes [afc_pkg::NUM_PLANES],
	output afc_pkg::front_stat_t           stat,
	output logic                           out_valid,
	output afc_pkg::q_entry_t              out_entry
);

	logic signed [afc_pkg::COEF_W-1:0]     coef_c [afc_pkg::NUM_PLANES][afc_pkg::NUM_AXES];
	logic signed [afc_pkg::COORD_BITS-1:0] pick_c [afc_pkg::NUM_PLANES][afc_pkg::NUM_AXES];
	afc_pkg::prod_t                        prod_c [afc_pkg::NUM_PLANES][afc_pkg::NUM_AXES];

	afc_pkg::prod_t                        prod_s1 [afc_pkg::NUM_PLANES][afc_pkg::NUM_AXES];
	logic signed [afc_pkg::COEF_W-1:0]     d_s1 [afc_pkg::NUM_PLANES];
	logic                                  valid_s1;
	logic                                  last_s1;

	afc_pkg::sum_t                         sum_c [afc_pkg::NUM_PLANES];
	logic [afc_pkg::NUM_PLANES-1:0]        pass_c;

	logic                                  valid_s2;
	logic                                  vis_s2;
	logic                                  last_s2;

	// p-vertex: a negative component takes the min corner, otherwise the max
	always_comb begin
		for (int p = 0; p < afc_pkg::NUM_PLANES; p++) begin
			for (int k = 0; k < afc_pkg::NUM_AXES; k++) begin
				coef_c[p][k] = $signed(planes[p][k*afc_pkg::COEF_W +: afc_pkg::COEF_W]);
				pick_c[p][k] = coef_c[p][k][afc_pkg::COEF_W-1]
					? $signed(in_data[k*afc_pkg::COORD_BITS +: afc_pkg::COORD_BITS])
					: $signed(in_data[(afc_pkg::NUM_AXES+k)*afc_pkg::COORD_BITS +:
						afc_pkg::COORD_BITS]);
				prod_c[p][k] = afc_pkg::prod_t'(coef_c[p][k]) * afc_pkg::prod_t'(pick_c[p][k]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= prod_c;
		last_s1 <= in_last;
		for (int p = 0; p < afc_pkg::NUM_PLANES; p++) begin
			d_s1[p] <= $signed(planes[p][afc_pkg::NUM_AXES*afc_pkg::COEF_W +: afc_pkg::COEF_W]);
		end
	end

	// Exact plane distance, d scaled up to the product weight
	always_comb begin
		for (int p = 0; p < afc_pkg::NUM_PLANES; p++) begin
			sum_c[p] = afc_pkg::sum_t'(prod_s1[p][0]) + afc_pkg::sum_t'(prod_s1[p][1])
				+ afc_pkg::sum_t'(prod_s1[p][2])
				+ afc_pkg::sum_t'($signed({d_s1[p], {afc_pkg::D_SHIFT{1'b0}}}));
			pass_c[p] = ~sum_c[p][afc_pkg::SUM_W-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		vis_s2  <= &pass_c;
		last_s2 <= last_s1;
	end

	assign stat.v_s1      = valid_s1;
	assign stat.v_s2      = valid_s2;
	assign out_valid      = valid_s2;
	assign out_entry.vis  = vis_s2;
	assign out_entry.last = last_s2;

endmodule

### rtl/core/afc_queue.sv
module afc_queue (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	input  afc_pkg::q_entry_t           push_entry,
	input  logic                        pop,
	output afc_pkg::q_entry_t           head_entry,
	output logic                        not_empty,
	output logic [afc_pkg::QLVL_W-1:0]  level
);

	afc_pkg::q_entry_t               store_q [afc_pkg::QDEPTH];
	logic [afc_pkg::QPTR_W-1:0]      wr_ptr_q;
	logic [afc_pkg::QPTR_W-1:0]      rd_ptr_q;
	logic [afc_pkg::QLVL_W-1:0]      count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + afc_pkg::QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + afc_pkg::QPTR_W'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + afc_pkg::QLVL_W'(1);
				2'b01:   count_q <= count_q - afc_pkg::QLVL_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			store_q[wr_ptr_q] <= push_entry;
		end
	end

	assign head_entry = store_q[rd_ptr_q];
	assign not_empty  = (count_q != '0);
	assign level      = count_q;

endmodule

### rtl/core/afc_back.sv
module afc_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	input  afc_pkg::q_entry_t               in_entry,
	output logic                            in_pop,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [afc_pkg::OUT_DATA_W-1:0]  m_tdata,
	output logic                            m_tlast
);

	logic [afc_pkg::INDEX_BITS-1:0] box_q;
	logic [afc_pkg::CNT_W-1:0]      total_q;
	logic                           ovf_q;
	logic [afc_pkg::CNT_W-1:0]      total_next;

	logic                           m_tvalid_q;
	logic [afc_pkg::INDEX_BITS-1:0] m_idx_q;
	logic                           m_vis_q;
	logic [afc_pkg::CNT_W-1:0]      m_cnt_q;
	logic                           m_ovf_q;
	logic                           m_last_q;

	// Advance when the output register is free or being drained
	assign in_pop = in_valid && (!m_tvalid_q || m_tready);

	// Saturate at 2^INDEX_BITS: the top bit set means the count is full
	assign total_next = (in_entry.vis && !total_q[afc_pkg::CNT_W-1])
		? total_q + afc_pkg::CNT_W'(1) : total_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_q      <= '0;
			total_q    <= '0;
			ovf_q      <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (in_pop) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (in_pop) begin
				if (in_entry.last) begin
					box_q   <= '0;
					total_q <= '0;
					ovf_q   <= 1'b0;
				end else begin
					total_q <= total_next;
					// Hold the top index once it has been handed out
					if (&box_q) begin
						ovf_q <= 1'b1;
					end else begin
						box_q <= box_q + afc_pkg::INDEX_BITS'(1);
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_pop) begin
			m_idx_q  <= box_q;
			m_vis_q  <= in_entry.vis;
			m_cnt_q  <= total_next;
			m_ovf_q  <= ovf_q;
			m_last_q <= in_entry.last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = afc_pkg::OUT_DATA_W'({m_ovf_q, m_cnt_q, m_vis_q, m_idx_q});
	assign m_tlast  = m_last_q;

endmodule

### rtl/core/aabb_frustum_cull_top.sv
// Channel  | Handshake          | Payload
// ---------+--------------------+--------------------------------------------------------
// s_       | s_tvalid/s_tready  | tdata min/max x,y,z corners; tlast last_in_batch
// m_       | m_tvalid/m_tready  | tdata index, visible, count, overflow; tlast batch_end
// cfg_     | cfg_we             | cfg_idx selects the plane, cfg_wdata is a,b,c,d
//
// One box per cycle sustained while m_tready stays high; an accepted request passes the
// multiply stage, the plane-sum stage and the queue write, then the output register.
// The eighteen 16x16 multipliers and the per-plane sums are split over two stages.
// arst_n clears all control state, counters and the plane registers.
// s_tready drops only when the four-entry queue could not take a new box on top of the
// boxes still in the two front stages; m_tready low stalls just the counter stage.
module aabb_frustum_cull_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// [15:0] min_x, [31:16] min_y, [47:32] min_z,
	// [63:48] max_x, [79:64] max_y, [95:80] max_z
	input  logic [afc_pkg::IN_DATA_W-1:0]    s_tdata,
	input  logic                             s_tlast,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// [15:0] object_index, [16] is_visible, [33:17] visible_count,
	// [34] count_overflow, [39:35] zero
	output logic [afc_pkg::OUT_DATA_W-1:0]   m_tdata,
	output logic                             m_tlast,
	input  logic                             cfg_we,
	input  logic [afc_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [afc_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

	afc_pkg::plane_t             planes_q [afc_pkg::NUM_PLANES];
	afc_pkg::front_stat_t        front_stat;
	logic                        q_push;
	afc_pkg::q_entry_t           q_push_entry;
	logic                        q_pop;
	afc_pkg::q_entry_t           q_head;
	logic                        q_not_empty;
	logic [afc_pkg::QLVL_W-1:0]  q_level;
	logic [afc_pkg::QLVL_W-1:0]  committed;
	logic                        in_accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < afc_pkg::NUM_PLANES; p++) begin
				planes_q[p] <= '0;
			end
		end else if (cfg_we && cfg_idx <= afc_pkg::REG_PLANE_FAR) begin
			planes_q[cfg_idx] <= cfg_wdata;
		end
	end

	// Reserve queue room for every box already inside the front stages
	assign committed = q_level + afc_pkg::QLVL_W'(front_stat.v_s1)
		+ afc_pkg::QLVL_W'(front_stat.v_s2);
	assign s_tready  = committed < afc_pkg::QLVL_W'(afc_pkg::QDEPTH);
	assign in_accept = s_tvalid && s_tready;

	afc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_accept),
		.in_data   (s_tdata),
		.in_last   (s_tlast),
		.planes    (planes_q),
		.stat      (front_stat),
		.out_valid (q_push),
		.out_entry (q_push_entry)
	);

	afc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_push_entry),
		.pop        (q_pop),
		.head_entry (q_head),
		.not_empty  (q_not_empty),
		.level      (q_level)
	);

	afc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (q_not_empty),
		.in_entry (q_head),
		.in_pop   (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

`ifndef SYNTHESIS
	a_queue_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		q_push && !q_pop |-> q_level != afc_pkg::QLVL_W'(afc_pkg::QDEPTH))
		else $error("queue written while full");

	a_credit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		committed <= afc_pkg::QLVL_W'(afc_pkg::QDEPTH))
		else $error("front stages hold more boxes than the queue can take");

	a_ovf_top_index: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[afc_pkg::INDEX_BITS + afc_pkg::CNT_W + 1]
			|-> &m_tdata[afc_pkg::INDEX_BITS-1:0])
		else $error("overflow reported below the top index");

	a_pipe_to_queue: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> ##1 q_push)
		else $error("accepted box did not reach the queue");
`endif

endmodule
